### rtl/largest_ones_square_area_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Property shorthands for the checker file of the square finder.
// ----------------------------------------------------------------------------
`ifndef LARGEST_ONES_SQUARE_AREA_CORE_MACROS_SVH
`define LARGEST_ONES_SQUARE_AREA_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define LOSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define LOSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/losa_pkg.sv
// ----------------------------------------------------------------------------
// losa_pkg
// Types and constants of the largest all-ones square finder.
// ----------------------------------------------------------------------------
package losa_pkg;

  localparam int MAX_WIDTH_DEF = 256;
  localparam int ROW_W         = 9;
  localparam int SIDE_W        = 9;
  localparam int AREA_W        = 17;

  typedef struct packed {
    logic cell_req;
    logic last_cell;
  } in_data_t;

  typedef struct packed {
    logic [AREA_W-1:0] max_area;
    logic [SIDE_W-1:0] max_side;
  } out_data_t;

endpackage

### rtl/losa_linebuf.sv
// ----------------------------------------------------------------------------
// losa_linebuf
// Previous-row line buffer: one write port, one registered read port, with
// bypass when the read and the write hit the same entry in one cycle.
// ----------------------------------------------------------------------------
module losa_linebuf #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [AW-1:0]                 wr_addr,
  input  logic [losa_pkg::SIDE_W-1:0]   wr_data,
  input  logic [AW-1:0]                 rd_addr,
  output logic [losa_pkg::SIDE_W-1:0]   rd_data
);
  import losa_pkg::*;

  logic [SIDE_W-1:0] mem [DEPTH];
  logic [SIDE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // forward the fresh write on a same-entry read
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/largest_ones_square_area_core.sv
// ----------------------------------------------------------------------------
// largest_ones_square_area_core
// Largest all-ones square in a raster-order binary matrix, by a row-by-row
// dynamic program over a previous-row line buffer.
// ----------------------------------------------------------------------------
// Takes one cell per clock and reports side and area of the largest square of
// ones on the beat after the cell marked last_cell. Each cell's side is the
// minimum of its left, up and up-left sides plus one (zero for a zero cell);
// left and up-left live in registers, up comes from the line buffer, whose
// read for the next column is issued ahead, from the next-column index, so that the single
// registered read port keeps pace at one cell per cycle. The input stalls
// only when a last-cell beat arrives while the previous result is held
// stalled in the output register. cfg_wdata sets the row width (0 acts as 1,
// values above MAX_WIDTH saturate); write it only between matrices. The buffer
// needs no clearing after reset: the first row never reads it.
// ----------------------------------------------------------------------------
module largest_ones_square_area_core #(
  parameter int MAX_WIDTH = losa_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  losa_pkg::in_data_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output losa_pkg::out_data_t           out_data,
  input  logic                          cfg_we,
  input  logic [losa_pkg::ROW_W-1:0]    cfg_wdata
);
  import losa_pkg::*;

  localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CMPW = ((CW > ROW_W) ? CW : ROW_W) + 1;
  localparam int WLIM = (MAX_WIDTH < 511) ? MAX_WIDTH : 511;
  localparam logic [ROW_W-1:0] WLIM_V = WLIM[ROW_W-1:0];
  localparam logic [ROW_W-1:0] W_ONE  = ROW_W'(1);

  function automatic logic [ROW_W-1:0] clip_width(input logic [ROW_W-1:0] rw);
    logic [ROW_W-1:0] w;
    w = (rw == '0) ? W_ONE : rw;
    if (w > WLIM_V) begin
      w = WLIM_V;
    end
    return w;
  endfunction

  function automatic logic [SIDE_W-1:0] min3(input logic [SIDE_W-1:0] a,
                                             input logic [SIDE_W-1:0] b,
                                             input logic [SIDE_W-1:0] c);
    logic [SIDE_W-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  logic [ROW_W-1:0]  row_width_r;
  logic [CW-1:0]     col_r, col_nxt;
  logic [SIDE_W-1:0] left_r, diag_r, best_r;
  logic              first_row_r;
  logic              out_valid_r;
  out_data_t         out_data_r;

  logic [ROW_W-1:0]  w_use, w_nxt;
  logic              accept;
  logic [SIDE_W-1:0] up_buf, up, diag, left, side, best_upd;
  logic              col0, last_col;
  logic [CMPW-1:0]   col_ext, col_inc, col_adv;
  logic [2*SIDE_W-1:0] area_full;

  assign in_stall = out_valid_r && out_stall && in_data.last_cell;
  assign accept   = in_valid && !in_stall;

  assign w_use = clip_width(row_width_r);
  assign w_nxt = clip_width(cfg_we ? cfg_wdata : row_width_r);

  assign col_ext  = CMPW'(col_r);
  assign col_inc  = col_ext + CMPW'(1);
  assign col0     = (col_r == '0);
  assign last_col = (col_inc >= CMPW'(w_use));

  assign up   = first_row_r ? '0 : up_buf;
  assign diag = (first_row_r || col0) ? '0 : diag_r;
  assign left = col0 ? '0 : left_r;
  assign side = in_data.cell_req ? (min3(left, up, diag) + SIDE_W'(1)) : '0;

  assign best_upd  = (side > best_r) ? side : best_r;
  assign area_full = best_upd * best_upd;

  // next column, folded back to zero if a narrower width is written meanwhile
  always_comb begin
    if (!accept) begin
      col_adv = col_ext;
    end else if (in_data.last_cell || last_col) begin
      col_adv = '0;
    end else begin
      col_adv = col_inc;
    end
    col_nxt = (col_adv >= CMPW'(w_nxt)) ? '0 : col_adv[CW-1:0];
  end

  losa_linebuf #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_linebuf (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (col_r),
    .wr_data (side),
    .rd_addr (col_nxt),
    .rd_data (up_buf)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= WLIM_V;
    end else if (cfg_we) begin
      row_width_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      left_r      <= '0;
      diag_r      <= '0;
      best_r      <= '0;
      first_row_r <= 1'b1;
    end else begin
      col_r <= col_nxt;
      if (accept) begin
        if (in_data.last_cell) begin
          // end of matrix: back to a fresh stream
          left_r      <= '0;
          diag_r      <= '0;
          best_r      <= '0;
          first_row_r <= 1'b1;
        end else begin
          left_r <= side;
          diag_r <= up;
          best_r <= best_upd;
          if (last_col) begin
            first_row_r <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && in_data.last_cell) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_data.last_cell) begin
      out_data_r.max_area <= area_full[AREA_W-1:0];
      out_data_r.max_side <= best_upd;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/losa_chk.sv
// ----------------------------------------------------------------------------
// losa_chk
// Port-level checks of the square finder, bound to the top level.
// ----------------------------------------------------------------------------
`include "largest_ones_square_area_core_macros.svh"

module losa_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input losa_pkg::in_data_t            in_data,
  input logic                          out_valid,
  input logic                          out_stall,
  input losa_pkg::out_data_t           out_data
);
  import losa_pkg::*;

  logic [2*SIDE_W-1:0] side_sq;
  assign side_sq = out_data.max_side * out_data.max_side;

  // a stalled result beat holds
  `LOSA_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                    out_valid && $stable(out_data),
                    "result beat dropped or changed under stall")

  // a taken last cell always yields a result on the next beat
  `LOSA_ASSERT_NEXT(a_last_gives_result, in_valid && !in_stall && in_data.last_cell,
                    out_valid, "no result after last cell")

  // a fresh result only follows a taken last cell
  `LOSA_ASSERT_NOW(a_no_spurious, out_valid && !$past(out_valid),
                   $past(in_valid && !in_stall && in_data.last_cell),
                   "result without last cell")

  // area agrees with side
  `LOSA_ASSERT_NOW(a_area_side, out_valid, out_data.max_area == side_sq[AREA_W-1:0],
                   "area does not match side")

endmodule

bind largest_ones_square_area_core losa_chk u_losa_chk (.*);
